// ===== hw/rtl/aes256_pkg.sv =====
`timescale 1ns / 1ps
package aes256_pkg;

	typedef logic [0:15][7:0] blk_t;
	typedef logic [0:7][31:0] win_t;

	localparam int unsigned NumCfg = 6;
	localparam logic [2:0] CFG_KEY0 = 3'd0;
	localparam logic [2:0] CFG_KEY1 = 3'd1;
	localparam logic [2:0] CFG_KEY2 = 3'd2;
	localparam logic [2:0] CFG_KEY3 = 3'd3;
	localparam logic [2:0] CFG_IVH  = 3'd4;
	localparam logic [2:0] CFG_IVL  = 3'd5;
	localparam logic [3:0] LAST_ROUND = 4'd14;
	localparam logic [3:0] LAST_BYTE  = 4'd15;

	typedef struct packed {
		logic       start;
		logic       wr_byte;
		logic [3:0] byte_idx;
		logic       pad;
		logic [3:0] pad_from;
		logic       load;
		logic       round;
		logic       final_rnd;
		logic [3:0] rnd;
		logic [3:0] out_idx;
	} cmd_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// Round constant for the key words generated while leaving round r.
	function automatic logic [7:0] rcon(input logic [3:0] r);
		logic [7:0] v;
		case (r[3:1])
			3'd0: v = 8'h01;
			3'd1: v = 8'h02;
			3'd2: v = 8'h04;
			3'd3: v = 8'h08;
			3'd4: v = 8'h10;
			3'd5: v = 8'h20;
			3'd6: v = 8'h40;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic blk_t sub_shift(input blk_t s);
		blk_t t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[c*4+r] = SBOX[s[((c + r) % 4) * 4 + r]];
			end
		end
		return t;
	endfunction

	function automatic blk_t mix_cols(input blk_t s);
		blk_t t;
		logic [7:0] a, b, d, e, x;
		for (int c = 0; c < 4; c++) begin
			a = s[c*4];
			b = s[c*4+1];
			d = s[c*4+2];
			e = s[c*4+3];
			x = a ^ b ^ d ^ e;
			t[c*4]   = a ^ x ^ xtime(a ^ b);
			t[c*4+1] = b ^ x ^ xtime(b ^ d);
			t[c*4+2] = d ^ x ^ xtime(d ^ e);
			t[c*4+3] = e ^ x ^ xtime(e ^ a);
		end
		return t;
	endfunction

	// Slides the eight-word key window ahead by four words.
	function automatic win_t key_next(input win_t w, input logic [3:0] r);
		logic [31:0] t, n0, n1, n2, n3;
		if (!r[0]) begin
			t = sub_word({w[7][23:0], w[7][31:24]}) ^ {rcon(r), 24'h0};
		end else begin
			t = sub_word(w[7]);
		end
		n0 = w[0] ^ t;
		n1 = w[1] ^ n0;
		n2 = w[2] ^ n1;
		n3 = w[3] ^ n2;
		return {w[4], w[5], w[6], w[7], n0, n1, n2, n3};
	endfunction

endpackage

// ===== hw/rtl/aes256_ctrl.sv =====
`timescale 1ns / 1ps
module aes256_ctrl
	import aes256_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic byte_present,
	input  logic message_end,
	output logic out_valid,
	input  logic out_ready,
	output logic block_last,
	output logic message_last,
	output cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_LOAD  = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_EMIT  = 5'b01000,
		ST_PAD   = 5'b10000
	} state_t;

	state_t     state_q, state_d;
	logic       in_msg_q, in_msg_d;
	logic       end_pend_q, end_pend_d;
	logic       last_q, last_d;
	logic [3:0] cnt_q, cnt_d;
	logic [3:0] rnd_q, rnd_d;
	logic [3:0] oidx_q, oidx_d;
	logic [3:0] cnt_eff, cnt_after;
	logic       full;

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = (state_q == ST_EMIT);
	assign block_last   = (oidx_q == LAST_BYTE);
	assign message_last = last_q && (oidx_q == LAST_BYTE);

	assign cnt_eff   = in_msg_q ? cnt_q : 4'd0;
	assign cnt_after = cnt_eff + {3'd0, byte_present};
	assign full      = byte_present && (cnt_eff == LAST_BYTE);

	always_comb begin
		state_d    = state_q;
		in_msg_d   = in_msg_q;
		end_pend_d = end_pend_q;
		last_d     = last_q;
		cnt_d      = cnt_q;
		rnd_d      = rnd_q;
		oidx_d     = oidx_q;
		cmd        = '0;
		cmd.rnd     = rnd_q;
		cmd.out_idx = oidx_q;
		cmd.byte_idx = cnt_eff;
		cmd.pad_from = cnt_after;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && (in_msg_q || byte_present || message_end)) begin
					cmd.start   = !in_msg_q;
					cmd.wr_byte = byte_present;
					if (full) begin
						cnt_d      = 4'd0;
						in_msg_d   = 1'b1;
						end_pend_d = message_end;
						last_d     = 1'b0;
						state_d    = ST_LOAD;
					end else if (message_end) begin
						cmd.pad  = 1'b1;
						cnt_d    = 4'd0;
						in_msg_d = 1'b0;
						last_d   = 1'b1;
						state_d  = ST_LOAD;
					end else begin
						cnt_d    = cnt_after;
						in_msg_d = 1'b1;
					end
				end
			end
			ST_PAD: begin
				cmd.pad      = 1'b1;
				cmd.pad_from = 4'd0;
				end_pend_d   = 1'b0;
				last_d       = 1'b1;
				in_msg_d     = 1'b0;
				state_d      = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				cmd.rnd  = 4'd0;
				rnd_d    = 4'd1;
				state_d  = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round     = 1'b1;
				cmd.final_rnd = (rnd_q == LAST_ROUND);
				rnd_d         = rnd_q + 4'd1;
				if (rnd_q == LAST_ROUND) begin
					oidx_d  = 4'd0;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_ready) begin
					oidx_d = oidx_q + 4'd1;
					if (oidx_q == LAST_BYTE) begin
						state_d = end_pend_q ? ST_PAD : ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_msg_q   <= 1'b0;
			end_pend_q <= 1'b0;
			last_q     <= 1'b0;
			cnt_q      <= 4'd0;
			rnd_q      <= 4'd0;
			oidx_q     <= 4'd0;
		end else begin
			state_q    <= state_d;
			in_msg_q   <= in_msg_d;
			end_pend_q <= end_pend_d;
			last_q     <= last_d;
			cnt_q      <= cnt_d;
			rnd_q      <= rnd_d;
			oidx_q     <= oidx_d;
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output open at once");
	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (rnd_q >= 4'd1 && rnd_q <= LAST_ROUND))
		else $error("round counter out of range");
	a_block_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && oidx_q == LAST_BYTE && !end_pend_q) |=> in_ready)
		else $error("block end did not return to idle");
	a_pad_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAD) |=> (state_q == ST_LOAD))
		else $error("pad block not encrypted");

endmodule

// ===== hw/rtl/aes256_dp.sv =====
`timescale 1ns / 1ps
module aes256_dp
	import aes256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic [7:0]  data_byte,
	input  cmd_t        cmd,
	output logic [7:0]  cipher_byte
);

	logic [63:0] cfg_q [NumCfg];
	win_t        key_q;
	win_t        win_q;
	blk_t        chain_q;
	blk_t        gbuf_q;
	blk_t        st_q;
	blk_t        s_sub, s_rnd;
	logic [7:0]  pad_val;

	assign pad_val = 8'(5'd16 - {1'b0, cmd.pad_from});
	assign s_sub   = sub_shift(st_q);
	assign s_rnd   = (cmd.final_rnd ? s_sub : mix_cols(s_sub)) ^ blk_t'(win_q[0:3]);
	assign cipher_byte = st_q[cmd.out_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumCfg; i++) begin
				cfg_q[i] <= 64'd0;
			end
		end else if (cfg_we && cfg_index < 3'(NumCfg)) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q   <= {cfg_q[CFG_KEY0], cfg_q[CFG_KEY1], cfg_q[CFG_KEY2], cfg_q[CFG_KEY3]};
			chain_q <= {cfg_q[CFG_IVH], cfg_q[CFG_IVL]};
		end else if (cmd.round && cmd.final_rnd) begin
			chain_q <= s_rnd;
		end
		for (int j = 0; j < 16; j++) begin
			if (cmd.wr_byte && cmd.byte_idx == 4'(j)) begin
				gbuf_q[j] <= data_byte;
			end else if (cmd.pad && 4'(j) >= cmd.pad_from) begin
				gbuf_q[j] <= pad_val;
			end
		end
		if (cmd.load) begin
			st_q  <= gbuf_q ^ chain_q ^ blk_t'(key_q[0:3]);
			win_q <= key_next(key_q, cmd.rnd);
		end else if (cmd.round) begin
			st_q  <= s_rnd;
			win_q <= key_next(win_q, cmd.rnd);
		end
	end

endmodule

// ===== hw/rtl/aes256_cbc_encryptor_top.sv =====
`timescale 1ns / 1ps
// AES-256 CBC encryptor with PKCS#7 padding.
// The input channel (in_valid/in_ready) takes one word per item: data_byte with
// byte_present, plus message_end to close the message. The output channel
// (out_valid/out_ready) returns one ciphertext byte per word, with block_last on
// the sixteenth byte of every block and message_last on the final byte.
// Key and IV are to be written by the user through cfg_we/cfg_index/cfg_data while
// the block is idle, which the block itself does not enforce; they are sampled by
// the first word of each message, so later writes only affect the next message.
// A block that becomes full takes a load step and fourteen rounds, one round
// per cycle through a single round unit with on-the-fly key expansion, then
// sixteen output bytes. A closing word on a full block adds a pad step and a
// second block. Words that do not complete a block are taken every cycle.
// The input is held off while a block is being encrypted or emitted; when the
// receiver stalls, the current byte simply holds on the output.
// Reset clears the configuration registers and returns the block to idle with
// no message open; no clearing pass is needed.
module aes256_cbc_encryptor_top
	import aes256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        message_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  cipher_byte,
	output logic        block_last,
	output logic        message_last
);

	cmd_t cmd;

	// The controller owns all sequencing; the datapath holds key, chain and state.
	aes256_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.byte_present (byte_present),
		.message_end  (message_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.block_last   (block_last),
		.message_last (message_last),
		.cmd          (cmd)
	);

	aes256_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.data_byte   (data_byte),
		.cmd         (cmd),
		.cipher_byte (cipher_byte)
	);

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the AES-256 CBC encryptor with PKCS#7 padding.
// A software AES-256 CBC model predicts every ciphertext byte from the words
// the block accepts; a monitor compares each returned byte against the oldest
// prediction, field by field.
module tb
	import aes256_pkg::*;
;

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       close;
	} in_word_t;

	typedef struct packed {
		logic [7:0] cbyte;
		logic       blk_last;
		logic       msg_last;
	} out_word_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        byte_present;
	logic        message_end;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  cipher_byte;
	logic        block_last;
	logic        message_last;

	aes256_cbc_encryptor_top dut (.*);

	// Stimulus queue, predicted ciphertext queue and scoreboard counters.
	in_word_t  pending_words[$];
	out_word_t cipher_expected[$];
	int        mismatches;
	int        bytes_checked;
	int        words_sent;
	int        idle_cycles;
	bit        timed_out;
	bit        in_acc;

	// Idling controls: a percentage for each side, and a long receiver stall.
	int        send_idle_pct;
	int        recv_idle_pct;
	int        hold_off_left;

	// Predictor copy of the registers and of the cipher state.
	logic [63:0] cfg_shadow [NumCfg];
	logic [31:0] sched_words [60];
	logic [7:0]  chain_bytes [16];
	logic [7:0]  gather_bytes [16];
	int          gather_fill;
	bit          msg_open;

	// Helpers written directly from the AES definition.
	function automatic logic [7:0] gf_double(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sbox_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	task automatic expand_schedule();
		logic [31:0] t;
		logic [7:0]  rc;
		for (int i = 0; i < 8; i++)
			sched_words[i] = (i % 2 == 0) ? cfg_shadow[i/2][63:32] : cfg_shadow[i/2][31:0];
		rc = 8'h01;
		for (int i = 8; i < 60; i++) begin
			t = sched_words[i-1];
			if (i % 8 == 0) begin
				t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = gf_double(rc);
			end else if (i % 8 == 4) begin
				t = sbox_word(t);
			end
			sched_words[i] = sched_words[i-8] ^ t;
		end
	endtask

	// Encrypts the gathered block in CBC mode and queues its sixteen bytes.
	task automatic encrypt_block(input bit closing);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a, b, c, d, x;
		for (int i = 0; i < 16; i++)
			s[i] = gather_bytes[i] ^ chain_bytes[i];
		for (int rnd = 0; rnd <= 14; rnd++) begin
			if (rnd > 0) begin
				for (int col = 0; col < 4; col++)
					for (int row = 0; row < 4; row++)
						t[col*4+row] = SBOX[s[((col + row) % 4) * 4 + row]];
				s = t;
				if (rnd < 14) begin
					for (int col = 0; col < 4; col++) begin
						a = s[col*4]; b = s[col*4+1]; c = s[col*4+2]; d = s[col*4+3];
						x = a ^ b ^ c ^ d;
						s[col*4]   = a ^ x ^ gf_double(a ^ b);
						s[col*4+1] = b ^ x ^ gf_double(b ^ c);
						s[col*4+2] = c ^ x ^ gf_double(c ^ d);
						s[col*4+3] = d ^ x ^ gf_double(d ^ a);
					end
				end
			end
			for (int i = 0; i < 16; i++)
				s[i] ^= sched_words[rnd*4 + i/4][31 - 8*(i%4) -: 8];
		end
		for (int i = 0; i < 16; i++) begin
			chain_bytes[i] = s[i];
			cipher_expected.push_back('{s[i], i == 15, closing && i == 15});
		end
	endtask

	// Predicts the results of one accepted word.
	task automatic predict_word(input in_word_t w);
		if (!msg_open) begin
			if (!w.present && !w.close)
				return;
			expand_schedule();
			for (int i = 0; i < 16; i++)
				chain_bytes[i] = (i < 8) ? cfg_shadow[CFG_IVH][63 - 8*i -: 8]
				                         : cfg_shadow[CFG_IVL][63 - 8*(i-8) -: 8];
			gather_fill = 0;
			msg_open = 1;
		end
		if (w.present) begin
			gather_bytes[gather_fill] = w.data;
			gather_fill++;
			if (gather_fill == 16) begin
				encrypt_block(0);
				gather_fill = 0;
			end
		end
		if (w.close) begin
			for (int k = gather_fill; k < 16; k++)
				gather_bytes[k] = 8'(16 - gather_fill);
			encrypt_block(1);
			gather_fill = 0;
			msg_open = 0;
		end
	endtask

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Records at the rising edge whether the offered word was taken.
	always @(posedge clk) begin
		in_acc <= arst_n && in_valid && in_ready;
	end

	// Driver: presents queued words at the falling edge. The payload holds until
	// the word is accepted, and valid never drops while a word is waiting.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_acc) begin
				void'(pending_words.pop_front());
				words_sent++;
			end
			if ((in_valid && !in_acc) ||
			    (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)) begin
				if (pending_words.size() > 0) begin
					in_valid     <= 1'b1;
					data_byte    <= pending_words[0].data;
					byte_present <= pending_words[0].present;
					message_end  <= pending_words[0].close;
				end else begin
					in_valid <= 1'b0;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver backpressure: a long hold-off counter wins over random idling.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_off_left > 0) begin
				hold_off_left <= hold_off_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Monitor: predicts on every accepted input word and checks every output
	// word against the oldest prediction. Also runs the inactivity watchdog.
	always @(posedge clk) begin
		out_word_t got;
		out_word_t exp_w;
		if (arst_n) begin
			if (in_valid && in_ready)
				predict_word('{data_byte, byte_present, message_end});
			if (out_valid && out_ready) begin
				got = '{cipher_byte, block_last, message_last};
				if (cipher_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: unexpected output word %h/%b/%b", cipher_byte,
						         block_last, message_last);
				end else begin
					exp_w = cipher_expected.pop_front();
					bytes_checked++;
					if (got !== exp_w) begin
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR: byte %0d expected %h/%b/%b got %h/%b/%b",
							         bytes_checked, exp_w.cbyte, exp_w.blk_last,
							         exp_w.msg_last, got.cbyte, got.blk_last, got.msg_last);
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles > 20000 && !timed_out) begin
			timed_out = 1;
			$display("ERROR: no activity for %0d cycles", idle_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_shadow[idx] = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_key_iv(input logic [63:0] k0, k1, k2, k3, ivh, ivl);
		write_reg(CFG_KEY0, k0);
		write_reg(CFG_KEY1, k1);
		write_reg(CFG_KEY2, k2);
		write_reg(CFG_KEY3, k3);
		write_reg(CFG_IVH, ivh);
		write_reg(CFG_IVL, ivl);
	endtask

	// Waits until the queues drain, then lets the block settle.
	task automatic wait_drained();
		while (pending_words.size() > 0 || in_valid || cipher_expected.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic push_message(input int len, input bit rand_data, input logic [7:0] fill);
		for (int i = 0; i < len; i++)
			pending_words.push_back('{rand_data ? 8'($urandom) : fill, 1'b1,
			                          i == len - 1});
		if (len == 0)
			pending_words.push_back('{8'($urandom), 1'b0, 1'b1});
	endtask

	initial begin
		int len;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		data_byte = '0;
		byte_present = 0;
		message_end = 0;
		out_ready = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_left = 0;
		mismatches = 0;
		bytes_checked = 0;
		words_sent = 0;
		idle_cycles = 0;
		timed_out = 0;
		in_acc = 0;
		msg_open = 0;
		gather_fill = 0;
		for (int i = 0; i < NumCfg; i++)
			cfg_shadow[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed part with the all-zero key and IV and no idling: an empty
		// message, an idle word, one byte, and a byte that fills a block while
		// also closing the message, so the pad block follows at once.
		push_message(0, 0, 8'h00);
		pending_words.push_back('{8'hff, 1'b0, 1'b0});
		push_message(1, 0, 8'hff);
		push_message(16, 0, 8'h00);
		wait_drained();

		// All-ones key and IV: a short message of extreme bytes, and a full block
		// followed by a separate end word.
		load_key_iv('1, '1, '1, '1, '1, '1);
		pending_words.push_back('{8'h00, 1'b1, 1'b0});
		pending_words.push_back('{8'hff, 1'b1, 1'b1});
		push_message(16, 0, 8'ha5);
		pending_words[$].close = 0;
		pending_words.push_back('{8'h00, 1'b0, 1'b1});
		wait_drained();

		// A register write while a message is open must not affect it.
		pending_words.push_back('{8'h5a, 1'b1, 1'b0});
		wait_drained();
		write_reg(CFG_KEY2, 64'h0123456789abcdef);
		pending_words.push_back('{8'h3c, 1'b1, 1'b1});
		wait_drained();

		// Random part: each phase loads a random key and IV, then runs messages of
		// random lengths, with random idling in every phase but the third. The second
		// phase starts with a long receiver stall so the block fills up and holds off its input.
		for (int phase = 0; phase < 4; phase++) begin
			load_key_iv({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			            {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
			send_idle_pct = (phase == 2) ? 0 : 35;
			recv_idle_pct = (phase == 2) ? 0 : 35;
			if (phase == 1)
				hold_off_left = 400;
			for (int m = 0; m < 3; m++) begin
				len = ($urandom_range(3) == 0) ? 16 * $urandom_range(1, 2)
				                               : $urandom_range(0, 20);
				if ($urandom_range(4) == 0)
					pending_words.push_back('{8'($urandom), 1'b0, 1'b0});
				push_message(len, 1, 8'h00);
			end
			wait_drained();
		end

		$display("Summary: %0d words sent, %0d ciphertext bytes checked over several keys",
		         words_sent, bytes_checked);
		$display("Covered empty, aligned and unaligned messages, idle words and backpressure.");
		if (mismatches == 0 && cipher_expected.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Mismatches: %0d, bytes still expected: %0d", mismatches,
			         cipher_expected.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
